/* src/rars_pkg.sv */
`timescale 1ns / 1ps
package rars_pkg;

  localparam int MaxCols  = 4;
  localparam int MaxOrder = 8;
  localparam int FracBits = 16;
  localparam int ColW     = $clog2(MaxCols);
  localparam int OrdW     = $clog2(MaxOrder);

  localparam logic [1:0] FUNC_BETA = 2'd0;
  localparam logic [1:0] FUNC_PHI  = 2'd1;
  localparam logic [1:0] FUNC_OBS  = 2'd2;

  localparam logic CFG_COLS  = 1'b0;
  localparam logic CFG_ORDER = 1'b1;

  localparam logic [62:0] SumMax = {63{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REG,
    ST_AR,
    ST_SQ,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic             capture;   // latch observation, init accumulator from y
    logic             mac_reg;   // subtract beta product at index
    logic             fin_reg;   // saturate accumulator into r and e start
    logic             mac_ar;    // subtract phi product at index
    logic             fin_ar;    // saturate into e
    logic             square;    // add e*e to running sum, shift history (clear it at series end)
    logic [OrdW-1:0]  idx;
  } cmd_t;

endpackage

/* src/rars_ctrl.sv */
`timescale 1ns / 1ps
module rars_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            func,
  input  logic [2:0]            ncols,
  input  logic [3:0]            order,
  input  logic                  out_valid,
  input  logic                  out_ready,
  output rars_pkg::cmd_t        cmd,
  output logic                  load_out
);
  import rars_pkg::*;

  state_t state, state_next;
  logic [OrdW:0] cnt, cnt_next;

  // next state
  always_comb begin
    state_next = state;
    cnt_next = cnt;
    case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (in_valid && func == FUNC_OBS) state_next = ST_REG;
      end
      ST_REG: begin
        if (cnt >= {1'b0, ncols}) begin
          state_next = ST_AR;
          cnt_next = '0;
        end else cnt_next = cnt + 1'b1;
      end
      ST_AR: begin
        if (cnt >= order) state_next = ST_SQ;
        else cnt_next = cnt + 1'b1;
      end
      ST_SQ: state_next = ST_OUT;
      ST_OUT: if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    cmd.idx = cnt[OrdW-1:0];
    in_ready = 1'b0;
    load_out = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.capture = in_valid && func == FUNC_OBS;
      end
      ST_REG: begin
        if (cnt >= {1'b0, ncols}) cmd.fin_reg = 1'b1;
        else cmd.mac_reg = 1'b1;
      end
      ST_AR: begin
        if (cnt >= order) cmd.fin_ar = 1'b1;
        else cmd.mac_ar = 1'b1;
      end
      ST_SQ: cmd.square = 1'b1;
      ST_OUT: load_out = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end

endmodule

/* src/rars_dp.sv */
`timescale 1ns / 1ps
module rars_dp (
  input  logic                clk,
  input  logic                rst,
  input  rars_pkg::cmd_t      cmd,
  input  logic                coef_we,
  input  logic [1:0]          func,
  input  logic [2:0]          coef_index,
  input  logic signed [31:0]  coef_value,
  input  logic signed [31:0]  y_value,
  input  logic signed [31:0]  x_col0,
  input  logic signed [31:0]  x_col1,
  input  logic signed [31:0]  x_col2,
  input  logic signed [31:0]  x_col3,
  input  logic                end_of_series,
  output logic signed [31:0]  e_val,
  output logic [62:0]         sum_val,
  output logic                last
);
  import rars_pkg::*;

  logic signed [31:0] beta [MaxCols];
  logic signed [31:0] phi  [MaxOrder];
  logic signed [31:0] hist [MaxOrder];
  logic signed [31:0] xr   [MaxCols];
  logic signed [63:0] acc;
  logic signed [31:0] r_val;
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod, prod_fl, sat_in;
  logic signed [31:0] sat_out;
  logic [63:0] sq, sum_wide;

  // coefficient loads
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MaxCols; i++) beta[i] <= '0;
      for (int i = 0; i < MaxOrder; i++) phi[i] <= '0;
    end else if (coef_we) begin
      if (func == FUNC_BETA && {1'b0, coef_index} < 4'(MaxCols))
        beta[coef_index[ColW-1:0]] <= coef_value;
      if (func == FUNC_PHI && {1'b0, coef_index} < 4'(MaxOrder))
        phi[coef_index[OrdW-1:0]] <= coef_value;
    end
  end

  // shared multiplier operand select
  always_comb begin
    if (cmd.mac_reg) begin
      ma = beta[cmd.idx[ColW-1:0]];
      mb = xr[cmd.idx[ColW-1:0]];
    end else if (cmd.mac_ar) begin
      ma = phi[cmd.idx];
      mb = hist[cmd.idx];
    end else begin
      ma = e_val;
      mb = e_val;
    end
  end

  assign prod    = ma * mb;
  assign prod_fl = prod >>> FracBits;
  assign sat_in  = acc;
  assign sat_out = (sat_in > 64'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                   (sat_in < -64'sh80000000) ? 32'sh80000000 : sat_in[31:0];
  assign sq       = prod;
  assign sum_wide = {1'b0, sum_val} + sq;

  // accumulator, residuals, history and running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MaxOrder; i++) hist[i] <= '0;
      sum_val <= '0;
      last <= 1'b0;
    end else begin
      if (cmd.capture) begin
        acc <= 64'(y_value);
        xr[0] <= x_col0;
        xr[1] <= x_col1;
        xr[2] <= x_col2;
        xr[3] <= x_col3;
        last <= end_of_series;
        // a closed series starts its sum again with the next observation
        if (last) sum_val <= '0;
      end
      if (cmd.mac_reg || cmd.mac_ar) acc <= acc - prod_fl;
      if (cmd.fin_reg) begin
        r_val <= sat_out;
        acc <= 64'(sat_out);
      end
      if (cmd.fin_ar) e_val <= sat_out;
      if (cmd.square) begin
        if (last) begin
          for (int i = 0; i < MaxOrder; i++) hist[i] <= '0;
        end else begin
          for (int i = MaxOrder - 1; i > 0; i--) hist[i] <= hist[i-1];
          hist[0] <= r_val;
        end
        sum_val <= sum_wide[63] ? SumMax : sum_wide[62:0];
      end
    end
  end

endmodule

/* src/regression_ar_residual_sumsq_top.sv */
`timescale 1ns / 1ps
// regression residual with ar(p) whitening and running sum of squares
// input channel in_valid/in_ready carries one word: a beta load (func 0),
// a phi load (func 1) or an observation (func 2); loads give no result and
// func 3 is dropped.
// an observation runs through one shared 32x32 multiplier: a step per
// regressor column, a step per ar tap and one for the square bring it to the
// output register, and the next word is taken only after that, since a word
// is accepted only while the block is idle.
// output channel out_valid/out_ready: residual, sum_of_squares, series_done.
// the result waits in the output register while the receiver stalls; a
// following observation is accepted but holds in its last step until that
// register is free again.
// configuration: cfg_we, cfg_index (0 column_count, 1 ar_order), cfg_data;
// the user must write it only while idle, the block does not enforce it.
// reset (synchronous, active high) clears coefficients, history, sum and
// sets column_count to 1, ar_order to 0.
// the result closing a series (end_of_series) includes that sample; history
// and sum are then cleared.
module regression_ar_residual_sumsq_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [3:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func,
  input  logic [2:0]         coef_index,
  input  logic signed [31:0] coef_value,
  input  logic signed [31:0] y_value,
  input  logic signed [31:0] x_col0,
  input  logic signed [31:0] x_col1,
  input  logic signed [31:0] x_col2,
  input  logic signed [31:0] x_col3,
  input  logic               end_of_series,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] residual,
  output logic [62:0]        sum_of_squares,
  output logic               series_done
);
  import rars_pkg::*;

  logic [2:0] column_count;
  logic [3:0] ar_order;
  logic [2:0] ncols;
  logic [3:0] order;
  cmd_t cmd;
  logic load_out;
  logic signed [31:0] e_val;
  logic [62:0] sum_val;
  logic last;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= 3'd1;
      ar_order <= 4'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLS: column_count <= cfg_data[2:0];
        CFG_ORDER: ar_order <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp to supported sizes
  assign ncols = (column_count > 3'(MaxCols)) ? 3'(MaxCols) : column_count;
  assign order = (ar_order > 4'(MaxOrder)) ? 4'(MaxOrder) : ar_order;

  rars_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .func, .ncols, .order,
    .out_valid, .out_ready, .cmd, .load_out
  );

  rars_dp u_dp (
    .clk, .rst, .cmd,
    .coef_we(in_valid && in_ready),
    .func, .coef_index, .coef_value, .y_value,
    .x_col0, .x_col1, .x_col2, .x_col3, .end_of_series,
    .e_val, .sum_val, .last
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (load_out) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      residual <= e_val;
      sum_of_squares <= sum_val;
      series_done <= last;
    end
  end

  // sum seen before each square, for the growth check; sum must never fall
  // within a series
  logic [62:0] sum_shadow;
  always_ff @(posedge clk) begin
    if (cmd.square) sum_shadow <= sum_val;
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> !(out_valid && !out_ready && load_out)) else $error("accept clash");
  a_load_from_out: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid) else $error("output not loaded");
  a_sum_grows: assert property (@(posedge clk) disable iff (rst)
    ($past(cmd.square) && !$past(last)) |-> (sum_val >= sum_shadow)) else $error("sum fell");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.mac_reg, cmd.fin_reg, cmd.mac_ar, cmd.fin_ar, cmd.square}))
    else $error("command clash");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
  import rars_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic               cfg_index = 1'b0;
  logic [3:0]         cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         func = '0;
  logic [2:0]         coef_index = '0;
  logic signed [31:0] coef_value = '0;
  logic signed [31:0] y_value = '0;
  logic signed [31:0] x_col0 = '0;
  logic signed [31:0] x_col1 = '0;
  logic signed [31:0] x_col2 = '0;
  logic signed [31:0] x_col3 = '0;
  logic               end_of_series = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] residual;
  logic [62:0]        sum_of_squares;
  logic               series_done;

  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam int CycleLimit = 2000000;

  typedef struct packed {
    logic [1:0]         fn;
    logic [2:0]         idx;
    logic signed [31:0] cv;
    logic signed [31:0] y;
    logic signed [31:0] x0;
    logic signed [31:0] x1;
    logic signed [31:0] x2;
    logic signed [31:0] x3;
    logic               last;
  } word_t;

  typedef struct packed {
    logic signed [31:0] e;
    logic [62:0]        ss;
    logic               done;
  } whitened_t;

  int errors = 0;
  int cycles = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // whitening predictor and queue of expected residuals
  class residual_board;
    logic signed [31:0] beta [MaxCols];
    logic signed [31:0] phi [MaxOrder];
    logic signed [31:0] hist [MaxOrder];
    logic [62:0]        acc_sq;
    logic [2:0]         cols;
    logic [3:0]         order;
    whitened_t          pending [$];

    function new();
      foreach (beta[i]) beta[i] = '0;
      foreach (phi[i]) phi[i] = '0;
      foreach (hist[i]) hist[i] = '0;
      acc_sq = '0;
      cols = 3'd1;
      order = 4'd0;
    endfunction

    function automatic logic signed [63:0] mulf(logic signed [31:0] a, logic signed [31:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b);
      return p >>> FracBits;  // arithmetic shift is floor
    endfunction

    function automatic logic signed [31:0] sat(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    function void note_word(word_t w);
      logic signed [31:0] xs [4];
      logic signed [63:0] acc;
      logic signed [31:0] r, e;
      logic [63:0] sq;
      int nc, no;
      whitened_t res;
      if (w.fn == FUNC_BETA) begin
        if (w.idx < MaxCols) beta[w.idx] = w.cv;
        return;
      end
      if (w.fn == FUNC_PHI) begin
        if (w.idx < MaxOrder) phi[w.idx] = w.cv;
        return;
      end
      if (w.fn != FUNC_OBS) return;
      xs[0] = w.x0; xs[1] = w.x1; xs[2] = w.x2; xs[3] = w.x3;
      nc = (cols > MaxCols) ? MaxCols : cols;
      no = (order > MaxOrder) ? MaxOrder : order;
      acc = 64'(w.y);
      for (int k = 0; k < nc; k++) acc -= mulf(beta[k], xs[k]);
      r = sat(acc);
      acc = 64'(r);
      for (int k = 0; k < no; k++) acc -= mulf(phi[k], hist[k]);
      e = sat(acc);
      sq = 64'(64'(e) * 64'(e));
      if (sq > {1'b0, SumMax - acc_sq}) acc_sq = SumMax;
      else acc_sq = acc_sq + sq[62:0];
      for (int k = MaxOrder - 1; k > 0; k--) hist[k] = hist[k-1];
      hist[0] = r;
      res.e = e; res.ss = acc_sq; res.done = w.last;
      pending.push_back(res);
      if (w.last) begin
        foreach (hist[i]) hist[i] = '0;
        acc_sq = '0;
      end
    endfunction

    task check_word(logic signed [31:0] e, logic [62:0] ss, logic done);
      whitened_t w;
      if (pending.size() == 0) begin
        report("unexpected word", {32'd0, e}, 64'd0);
        return;
      end
      w = pending.pop_front();
      if (e !== w.e) report("residual", {32'd0, e}, {32'd0, w.e});
      if (ss !== w.ss) report("sum_of_squares", {1'b0, ss}, {1'b0, w.ss});
      if (done !== w.done) report("series_done", {63'd0, done}, {63'd0, w.done});
    endtask
  endclass

  residual_board board = new();

  regression_ar_residual_sumsq_top DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // output side: random stall per word
  int out_wait = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        board.check_word(residual, sum_of_squares, series_done);
        out_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
      end
      if (out_wait > 0) begin
        out_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // valid stays high into the next word when there is no gap
  task automatic send_word(input word_t w, input bit no_gap = 0);
    int gap;
    gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    func <= w.fn; coef_index <= w.idx; coef_value <= w.cv; y_value <= w.y;
    x_col0 <= w.x0; x_col1 <= w.x1; x_col2 <= w.x2; x_col3 <= w.x3;
    end_of_series <= w.last;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    board.note_word(w);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_reg(input logic idx, input logic [3:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_COLS) board.cols = val[2:0];
    else board.order = val;
  endtask

  function automatic logic signed [31:0] pick_val();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      3: return $signed($urandom_range(0, 32'h1ffffff)) - 32'sh1000000;
      default: return $urandom();
    endcase
  endfunction

  function automatic word_t obs(input bit last);
    word_t w;
    w.fn = FUNC_OBS; w.idx = 3'($urandom()); w.cv = $urandom();
    w.y = pick_val(); w.x0 = pick_val(); w.x1 = pick_val();
    w.x2 = pick_val(); w.x3 = pick_val(); w.last = last;
    return w;
  endfunction

  function automatic word_t load(input logic [1:0] fn, input logic [2:0] idx,
                                 input logic signed [31:0] v);
    word_t w;
    w = obs(1'b0);
    w.fn = fn; w.idx = idx; w.cv = v;
    return w;
  endfunction

  initial begin
    word_t w;
    int sent;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, every func, out-of-range indexes, clamping
    set_reg(CFG_COLS, 4'd4);
    set_reg(CFG_ORDER, 4'd8);
    send_word(load(FUNC_BETA, 3'd0, 32'sh7fffffff));
    send_word(load(FUNC_BETA, 3'd3, 32'sh80000000));
    send_word(load(FUNC_BETA, 3'd7, 32'sh00010000));
    send_word(load(FUNC_PHI, 3'd0, 32'sh00008000));
    send_word(load(FUNC_PHI, 3'd7, 32'sh80000000));
    send_word(load(FUNC_NONE, 3'd1, 32'sh12345678));
    w = obs(1'b0);
    w.y = 32'sh7fffffff; w.x0 = 32'sh80000000; w.x3 = 32'sh7fffffff;
    send_word(w);
    w.y = 32'sh80000000; w.x0 = 32'sh7fffffff; w.x3 = 32'sh80000000;
    send_word(w);
    for (int i = 0; i < 8; i++) send_word(obs(i == 7));
    drain();
    set_reg(CFG_COLS, 4'd0);
    set_reg(CFG_ORDER, 4'd15);
    send_word(obs(1'b0));
    send_word(obs(1'b1));
    drain();
    set_reg(CFG_COLS, 4'd7);
    send_word(obs(1'b0), 1);
    send_word(obs(1'b1), 1);

    // random: coefficient reloads then series of observations
    sent = 24;
    for (int ph = 0; sent < 1650; ph++) begin
      drain();
      set_reg(CFG_COLS, ph % 5 == 0 ? 4'd4 : 4'($urandom_range(0, 7)));
      set_reg(CFG_ORDER, ph % 5 == 1 ? 4'd8 : 4'($urandom_range(0, 15)));
      for (int n = 0; n < 60 && sent < 1650; n++) begin
        case ($urandom_range(0, 19))
          0: w = load(FUNC_BETA, 3'($urandom()), pick_val());
          1: w = load(FUNC_PHI, 3'($urandom()), pick_val());
          2: w = load(FUNC_NONE, 3'($urandom()), $urandom());
          default: w = obs($urandom_range(0, 11) == 0);
        endcase
        send_word(w);
        sent++;
      end
    end

    drain();
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
